// ===== hw/rtl/rae_pkg.sv =====
// Shared types, codes and sizes for the register ALU instruction executor.
// No dependencies; the interfaces, the ALU and the top level import this package.
package rae_pkg;

    localparam int IMEM_DEPTH = 256;
    localparam int IMEM_AW    = (IMEM_DEPTH > 1) ? $clog2(IMEM_DEPTH) : 1;
    localparam int NUM_REGS   = 16;
    localparam int REG_AW     = 4;
    localparam int WORD_W     = 16;

    localparam logic [WORD_W-1:0] REG_RESET  = 16'd10;
    localparam logic [WORD_W-1:0] RX_MASK    = 16'hE000;
    localparam logic [WORD_W-1:0] RY_MASK    = 16'h1C00;
    localparam logic [WORD_W-1:0] OP_MASK    = 16'h001C;

    typedef enum logic [2:0] {
        REQ_EXEC     = 3'd0,
        REQ_LOAD     = 3'd1,
        REQ_WR_REG   = 3'd2,
        REQ_RD_REG   = 3'd3,
        REQ_RD_INSTR = 3'd4
    } req_type_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_AND = 3'd2,
        OP_OR  = 3'd3,
        OP_XOR = 3'd4,
        OP_SHL = 3'd5,
        OP_SHR = 3'd6,
        OP_CMP = 3'd7
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    function automatic logic [REG_AW-1:0] instr_rx(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] f;
        f = (w & RX_MASK) >> 13;
        return REG_AW'(f[2:0]);
    endfunction

    function automatic logic [REG_AW-1:0] instr_ry(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] f;
        f = (w & RY_MASK) >> 10;
        return REG_AW'(f[2:0]);
    endfunction

    function automatic alu_op_t instr_op(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] f;
        f = (w & OP_MASK) >> 2;
        return alu_op_t'(f[2:0]);
    endfunction

endpackage

// ===== hw/rtl/rae_if.sv =====
// Handshake channels of the executor: request words in, result words out.
// Depends on rae_pkg for the word width.
interface rae_req_if;
    import rae_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [7:0]        address;
    logic [3:0]        reg_index;
    logic [WORD_W-1:0] data;

    modport source (output valid, req_type, address, reg_index, data, input ready);
    modport sink   (input valid, req_type, address, reg_index, data, output ready);
endinterface

interface rae_rsp_if;
    import rae_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

// ===== hw/rtl/rae_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rae_alu.sv =====
// Eight-operation 16-bit ALU of the executor, purely combinational.
// Depends on rae_pkg for the operation codes.
module rae_alu
    import rae_pkg::*;
(
    input  alu_op_t           op,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] y
);

    logic big_shift;

    assign big_shift = |b[WORD_W-1:4];

    always_comb
    begin
        case (op)
            OP_ADD: y = a + b;
            OP_SUB: y = a - b;
            OP_AND: y = a & b;
            OP_OR:  y = a | b;
            OP_XOR: y = a ^ b;
            OP_SHL: y = big_shift ? '0 : (a << b[3:0]);
            OP_SHR: y = big_shift ? '0 : (a >> b[3:0]);
            default:
            begin
                if (a == b)
                begin
                    y = 16'd0;
                end
                else if (a > b)
                begin
                    y = 16'd1;
                end
                else
                begin
                    y = 16'd2;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/register_alu_instruction_executor.sv =====
// Top level of the register ALU instruction executor: sequencer, memories, output register.
// Depends on rae_pkg, rae_if, rae_ram and rae_alu.
//
//  channel | dir | payload                               | transfer
//  req     | in  | req_type, address, reg_index, data    | valid && ready
//  rsp     | out | result                                | valid && ready
//
// An execute word steps through accept, instruction fetch, register read
// and write back; every other word is accepted, then its result is loaded.
// The register file is two identical copies so both operands are read together.
// Reset clears the register valid bits; unwritten registers read as ten.
// A result waits in the output register; a stall there holds the sequencer
// in its last state, and a new word is taken only when the sequencer is idle.
module register_alu_instruction_executor
    import rae_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rae_req_if.sink   req,
    rae_rsp_if.source rsp
);

    state_t state_reg, state_next;

    req_type_t         type_reg, type_next;
    logic [7:0]        addr_reg, addr_next;
    logic [REG_AW-1:0] ridx_reg, ridx_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] instr_reg, instr_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic [NUM_REGS-1:0] rf_valid_reg, rf_valid_next;
    logic [REG_AW-1:0]   rfa_raddr_reg, rfb_raddr_reg;

    logic              accept;
    req_type_t         in_type;
    logic              slot_free;
    logic              in_range_in, in_range_reg;

    logic [IMEM_AW-1:0] imem_raddr;
    logic [WORD_W-1:0]  imem_rdata;
    logic               imem_we;

    logic [REG_AW-1:0]  rfa_raddr, rfb_raddr, rf_waddr;
    logic [WORD_W-1:0]  rfa_rdata, rfb_rdata, rf_wdata;
    logic [WORD_W-1:0]  opa, opb, alu_y, iword;
    logic               rf_we;

    assign accept    = req.valid && req.ready;
    assign in_type   = req_type_t'(req.req_type);
    assign slot_free = !out_valid_reg || rsp.ready;

    assign in_range_in  = 32'(req.address) < IMEM_DEPTH;
    assign in_range_reg = 32'(addr_reg) < IMEM_DEPTH;

    assign imem_we    = accept && (in_type == REQ_LOAD) && in_range_in;
    assign imem_raddr = (state_reg == S_IDLE) ? IMEM_AW'(req.address) : IMEM_AW'(addr_reg);
    assign iword      = in_range_reg ? imem_rdata : '0;

    rae_ram #(.WIDTH(WORD_W), .DEPTH(IMEM_DEPTH)) u_imem (
        .clk   (clk),
        .we    (imem_we),
        .waddr (IMEM_AW'(req.address)),
        .wdata (req.data),
        .raddr (imem_raddr),
        .rdata (imem_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rfa_raddr = req.reg_index;
            S_FETCH: rfa_raddr = instr_rx(iword);
            S_EXEC:  rfa_raddr = instr_rx(instr_reg);
            default: rfa_raddr = ridx_reg;
        endcase
        rfb_raddr = (state_reg == S_FETCH) ? instr_ry(iword) : instr_ry(instr_reg);
    end

    rae_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rfa_raddr),
        .rdata (rfa_rdata)
    );

    rae_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rfb_raddr),
        .rdata (rfb_rdata)
    );

    assign opa = rf_valid_reg[rfa_raddr_reg] ? rfa_rdata : REG_RESET;
    assign opb = rf_valid_reg[rfb_raddr_reg] ? rfb_rdata : REG_RESET;

    rae_alu u_alu (
        .op (instr_op(instr_reg)),
        .a  (opa),
        .b  (opb),
        .y  (alu_y)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.result = result_reg;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        addr_next      = addr_reg;
        ridx_next      = ridx_reg;
        res_next       = res_reg;
        instr_next     = instr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        result_next    = result_reg;
        rf_valid_next  = rf_valid_reg;
        rf_we          = 1'b0;
        rf_waddr       = req.reg_index;
        rf_wdata       = req.data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next = in_type;
                    addr_next = req.address;
                    ridx_next = req.reg_index;
                    unique case (in_type) inside
                        REQ_EXEC:
                        begin
                            state_next = S_FETCH;
                        end
                        REQ_RD_REG, REQ_RD_INSTR:
                        begin
                            state_next = S_READ;
                        end
                        REQ_LOAD:
                        begin
                            res_next   = req.data;
                            state_next = S_RESP;
                        end
                        REQ_WR_REG:
                        begin
                            rf_we                          = 1'b1;
                            rf_valid_next[req.reg_index]   = 1'b1;
                            res_next                       = req.data;
                            state_next                     = S_RESP;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                instr_next = iword;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    rf_we                               = 1'b1;
                    rf_waddr                            = instr_rx(instr_reg);
                    rf_wdata                            = alu_y;
                    rf_valid_next[instr_rx(instr_reg)]  = 1'b1;
                    out_valid_next                      = 1'b1;
                    result_next                         = alu_y;
                    state_next                          = S_IDLE;
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = (type_reg == REQ_RD_REG) ? opa : iword;
                    state_next     = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rf_valid_reg  <= rf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        addr_reg      <= addr_next;
        ridx_reg      <= ridx_next;
        res_reg       <= res_next;
        instr_reg     <= instr_next;
        result_reg    <= result_next;
        rfa_raddr_reg <= rfa_raddr;
        rfb_raddr_reg <= rfb_raddr;
    end

    a_exec_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_type == REQ_EXEC) |=> state_reg == S_FETCH)
        else $error("execute word did not enter instruction fetch");

    a_fetch_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> state_reg == S_EXEC)
        else $error("instruction fetch not followed by execute");

    a_exec_writeback_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && rf_we |=> out_valid_reg && (result_reg == $past(alu_y)))
        else $error("write back without matching result");

    a_reg_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_type == REQ_WR_REG) |=> rf_valid_reg[$past(req.reg_index)])
        else $error("register write did not mark the entry valid");

endmodule
